// File: sv/gis_pkg.sv
package gis_pkg;

   // Capacity of the interval store (range 2 to 64).
   localparam int MAX_INTERVALS = 32;
   // Wide enough to hold the count itself, 0 to MAX_INTERVALS.
   localparam int CNT_W = $clog2(MAX_INTERVALS + 1);

   localparam int DATA_W = 32;

   // Depth of the queue between front and back; a power of two.
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W = $clog2(QUEUE_DEPTH);
   localparam int QLVL_W = $clog2(QUEUE_DEPTH + 1);

   // One classified interval as it travels from the front to the back.
   typedef struct packed {
      logic signed [DATA_W-1:0] start_time;
      logic signed [DATA_W-1:0] finish_time;
      logic                     last_item;
      logic                     keep;      // fits in the store
      logic                     ovf;       // some word of the set was dropped so far
   } q_entry_type;

   // Occupancy of the queue.
   typedef struct packed {
      logic [QLVL_W-1:0] level;
      logic              full;
      logic              empty;
   } q_stat_type;

endpackage

// File: sv/gis_req_if.sv
interface gis_req_if;
   logic                              valid;
   logic                              ready;
   logic signed [gis_pkg::DATA_W-1:0] start_time;
   logic signed [gis_pkg::DATA_W-1:0] finish_time;
   logic                              last_item;

   modport source (output valid, output start_time, output finish_time, output last_item,
                   input ready);
   modport sink (input valid, input start_time, input finish_time, input last_item,
                 output ready);
endinterface

// File: sv/gis_rsp_if.sv
interface gis_rsp_if;
   logic                              valid;
   logic                              ready;
   logic signed [gis_pkg::DATA_W-1:0] sel_start;
   logic signed [gis_pkg::DATA_W-1:0] sel_finish;
   logic                              sel_last;
   logic                              overflowed;

   modport source (output valid, output sel_start, output sel_finish, output sel_last,
                   output overflowed, input ready);
   modport sink (input valid, input sel_start, input sel_finish, input sel_last,
                 input overflowed, output ready);
endinterface

// File: sv/greedy_interval_selector_core.sv
// Channel   Direction  Word contents
// req_bus   in         start_time, finish_time, last_item
// rsp_bus   out        sel_start, sel_finish, sel_last, overflowed
//
// Loading takes one word per cycle; the front and a four-word queue keep
// taking words while the back is busy, until the queue fills.
// After the word marked last reaches the back, the scan steps through the
// stored intervals in order and then sends the final selected word; a stall
// on the result side holds it. The set is held in a sorted shift chain of cells.
// Reset is synchronous and clears counters, flags and the queue; the
// interval cells are not cleared, since only cells of the current set are read.
// A stall on the result side holds the scan but not the front or the queue.
module greedy_interval_selector_core (
   input logic clock,
   input logic reset,
   gis_req_if.sink   req_bus,
   gis_rsp_if.source rsp_bus
);

   // Words travel from the front, which counts the set and marks dropped
   // intervals, through a short queue into the back, which sorts and scans.
   logic                 push_valid, push_ready;
   logic                 pop_valid, pop_ready;
   gis_pkg::q_entry_type push_entry, pop_entry;
   gis_pkg::q_stat_type  q_stat;

   gis_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_bus    (req_bus),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_entry (push_entry)
   );

   gis_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_entry (push_entry),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_entry  (pop_entry),
      .stat       (q_stat)
   );

   gis_back u_back (
      .clock     (clock),
      .reset     (reset),
      .pop_valid (pop_valid),
      .pop_ready (pop_ready),
      .pop_entry (pop_entry),
      .rsp_bus   (rsp_bus)
   );

   // The queue offers a word exactly when it holds one.
   a_pop_valid_level: assert property (@(posedge clock) disable iff (reset)
      pop_valid == (q_stat.level != '0))
      else $error("queue valid disagrees with its level");

   // A push without a pop raises the level by exactly one.
   a_level_push: assert property (@(posedge clock) disable iff (reset)
      (push_valid && push_ready && !(pop_valid && pop_ready))
      |=> q_stat.level == $past(q_stat.level) + 1'b1)
      else $error("queue level did not follow a push");

   // A pop without a push lowers the level by exactly one.
   a_level_pop: assert property (@(posedge clock) disable iff (reset)
      (pop_valid && pop_ready && !(push_valid && push_ready))
      |=> q_stat.level == $past(q_stat.level) - 1'b1)
      else $error("queue level did not follow a pop");

endmodule

// File: sv/gis_front.sv
module gis_front (
   input  logic                 clock,
   input  logic                 reset,
   gis_req_if.sink              req_bus,
   output logic                 push_valid,
   input  logic                 push_ready,
   output gis_pkg::q_entry_type push_entry
);

   logic [gis_pkg::CNT_W-1:0] count_ff, count_in;
   logic                      ovf_ff, ovf_in;
   logic                      keep;
   logic                      accept;

   // An interval is kept while the store still has room; otherwise it is
   // dropped and the set is flagged.
   always_comb begin
      keep    = count_ff < gis_pkg::CNT_W'(gis_pkg::MAX_INTERVALS);
      accept  = req_bus.valid && push_ready;
      ovf_in  = ovf_ff;
      count_in = count_ff;
      if (accept) begin
         if (req_bus.last_item) begin
            count_in = '0;
            ovf_in   = 1'b0;
         end else begin
            count_in = count_ff + gis_pkg::CNT_W'(keep);
            ovf_in   = ovf_ff | ~keep;
         end
      end
   end

   assign req_bus.ready          = push_ready;
   assign push_valid             = req_bus.valid;
   assign push_entry.start_time  = req_bus.start_time;
   assign push_entry.finish_time = req_bus.finish_time;
   assign push_entry.last_item   = req_bus.last_item;
   assign push_entry.keep        = keep;
   assign push_entry.ovf         = ovf_ff | ~keep;

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         ovf_ff   <= 1'b0;
      end else begin
         count_ff <= count_in;
         ovf_ff   <= ovf_in;
      end
   end

endmodule

// File: sv/gis_queue.sv
module gis_queue (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push_valid,
   output logic                 push_ready,
   input  gis_pkg::q_entry_type push_entry,
   output logic                 pop_valid,
   input  logic                 pop_ready,
   output gis_pkg::q_entry_type pop_entry,
   output gis_pkg::q_stat_type  stat
);

   gis_pkg::q_entry_type       slot_ff [gis_pkg::QUEUE_DEPTH];
   logic [gis_pkg::QPTR_W-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [gis_pkg::QLVL_W-1:0] level_ff;
   logic                       do_push, do_pop;

   always_comb begin
      stat.level = level_ff;
      stat.full  = level_ff == gis_pkg::QLVL_W'(gis_pkg::QUEUE_DEPTH);
      stat.empty = level_ff == '0;
      push_ready = ~stat.full;
      pop_valid  = ~stat.empty;
      do_push    = push_valid && push_ready;
      do_pop     = pop_valid && pop_ready;
   end

   assign pop_entry = slot_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         level_ff  <= '0;
      end else begin
         if (do_push) begin
            slot_ff[wr_ptr_ff] <= push_entry;
            wr_ptr_ff          <= wr_ptr_ff + 1'b1;
         end
         if (do_pop) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
         if (do_push && !do_pop) begin
            level_ff <= level_ff + 1'b1;
         end else if (do_pop && !do_push) begin
            level_ff <= level_ff - 1'b1;
         end
      end
   end

endmodule

// File: sv/gis_back.sv
module gis_back (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 pop_valid,
   output logic                 pop_ready,
   input  gis_pkg::q_entry_type pop_entry,
   gis_rsp_if.source            rsp_bus
);

   typedef enum logic {ST_LOAD, ST_SCAN} state_type;

   state_type                        state_ff;
   logic signed [gis_pkg::DATA_W-1:0] sta_ff [gis_pkg::MAX_INTERVALS];
   logic signed [gis_pkg::DATA_W-1:0] fin_ff [gis_pkg::MAX_INTERVALS];
   logic signed [gis_pkg::DATA_W-1:0] up_sta [gis_pkg::MAX_INTERVALS];
   logic signed [gis_pkg::DATA_W-1:0] up_fin [gis_pkg::MAX_INTERVALS];
   logic signed [gis_pkg::DATA_W-1:0] dn_sta [gis_pkg::MAX_INTERVALS];
   logic signed [gis_pkg::DATA_W-1:0] dn_fin [gis_pkg::MAX_INTERVALS];
   logic [gis_pkg::MAX_INTERVALS-1:0] le;
   logic [gis_pkg::MAX_INTERVALS-1:0] le_prev;
   logic [gis_pkg::CNT_W-1:0]        n_ff, rem_ff;
   logic                             set_ovf_ff;
   logic                             have_ff;
   logic signed [gis_pkg::DATA_W-1:0] pend_sta_ff, pend_fin_ff;
   logic                             out_valid_ff, out_last_ff, out_ovf_ff;
   logic signed [gis_pkg::DATA_W-1:0] out_sta_ff, out_fin_ff;
   logic                             out_free, head_take, emit_mid, scan_step, emit_end;
   logic                             out_load;
   logic                             load_fire, insert;

   always_comb begin
      out_free  = !out_valid_ff || rsp_bus.ready;
      pop_ready = state_ff == ST_LOAD;
      load_fire = pop_valid && pop_ready;
      insert    = load_fire && pop_entry.keep;
      head_take = !have_ff || (sta_ff[0] >= pend_fin_ff);
      emit_mid  = (state_ff == ST_SCAN) && (rem_ff != '0) && head_take && have_ff;
      scan_step = (state_ff == ST_SCAN) && (rem_ff != '0) && (!emit_mid || out_free);
      emit_end  = (state_ff == ST_SCAN) && (rem_ff == '0) && out_free;
      out_load  = (scan_step && emit_mid) || emit_end;

      // The stored cells stay sorted by finish time. Cells whose finish is not
      // greater than the new one keep their place, so equal finishes stay in
      // arrival order; the first greater cell takes the new interval and the
      // rest move up by one.
      for (int i = 0; i < gis_pkg::MAX_INTERVALS; i++) begin
         le[i] = (gis_pkg::CNT_W'(i) < n_ff) && (fin_ff[i] <= pop_entry.finish_time);
      end
      le_prev[0] = 1'b1;
      up_sta[0]  = pop_entry.start_time;
      up_fin[0]  = pop_entry.finish_time;
      for (int i = 1; i < gis_pkg::MAX_INTERVALS; i++) begin
         le_prev[i] = le[i-1];
         up_sta[i]  = sta_ff[i-1];
         up_fin[i]  = fin_ff[i-1];
      end
      // During the scan the cells move down so that the head is always cell 0.
      for (int i = 0; i < gis_pkg::MAX_INTERVALS - 1; i++) begin
         dn_sta[i] = sta_ff[i+1];
         dn_fin[i] = fin_ff[i+1];
      end
      dn_sta[gis_pkg::MAX_INTERVALS-1] = sta_ff[gis_pkg::MAX_INTERVALS-1];
      dn_fin[gis_pkg::MAX_INTERVALS-1] = fin_ff[gis_pkg::MAX_INTERVALS-1];
   end

   assign rsp_bus.valid      = out_valid_ff;
   assign rsp_bus.sel_start  = out_sta_ff;
   assign rsp_bus.sel_finish = out_fin_ff;
   assign rsp_bus.sel_last   = out_last_ff;
   assign rsp_bus.overflowed = out_ovf_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_LOAD;
         n_ff         <= '0;
         rem_ff       <= '0;
         have_ff      <= 1'b0;
         set_ovf_ff   <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         if (out_load) begin
            out_valid_ff <= 1'b1;
         end else if (rsp_bus.ready) begin
            out_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            ST_LOAD: begin
               if (insert) begin
                  for (int i = 0; i < gis_pkg::MAX_INTERVALS; i++) begin
                     if (!le[i]) begin
                        sta_ff[i] <= le_prev[i] ? pop_entry.start_time : up_sta[i];
                        fin_ff[i] <= le_prev[i] ? pop_entry.finish_time : up_fin[i];
                     end
                  end
                  n_ff <= n_ff + 1'b1;
               end
               if (load_fire && pop_entry.last_item) begin
                  set_ovf_ff <= pop_entry.ovf;
                  rem_ff     <= n_ff + gis_pkg::CNT_W'(pop_entry.keep);
                  have_ff    <= 1'b0;
                  state_ff   <= ST_SCAN;
               end
            end
            ST_SCAN: begin
               if (scan_step) begin
                  for (int i = 0; i < gis_pkg::MAX_INTERVALS; i++) begin
                     sta_ff[i] <= dn_sta[i];
                     fin_ff[i] <= dn_fin[i];
                  end
                  rem_ff <= rem_ff - 1'b1;
                  if (head_take) begin
                     pend_sta_ff <= sta_ff[0];
                     pend_fin_ff <= fin_ff[0];
                     have_ff     <= 1'b1;
                  end
                  if (emit_mid) begin
                     out_sta_ff   <= pend_sta_ff;
                     out_fin_ff   <= pend_fin_ff;
                     out_last_ff  <= 1'b0;
                     out_ovf_ff   <= set_ovf_ff;
                  end
               end
               if (emit_end) begin
                  out_sta_ff   <= pend_sta_ff;
                  out_fin_ff   <= pend_fin_ff;
                  out_last_ff  <= 1'b1;
                  out_ovf_ff   <= set_ovf_ff;
                  n_ff         <= '0;
                  have_ff      <= 1'b0;
                  state_ff     <= ST_LOAD;
               end
            end
            default: begin
               state_ff <= ST_LOAD;
            end
         endcase
      end
   end

endmodule
